// ===== rtl/mcpf_pkg.sv =====
package mcpf_pkg;

	localparam int unsigned OpW    = 3;
	localparam int unsigned ByteW  = 8;
	localparam int unsigned LenW   = 16;
	localparam int unsigned QosW   = 2;
	localparam int unsigned RemW   = 18;	// worst case CONNECT remaining length is 196621
	localparam int unsigned RlW    = 2;		// remaining-length byte count, 1..3
	localparam int unsigned IdxW   = 5;		// up to 18 bytes per input beat
	localparam int unsigned STdataW = 64;
	localparam int unsigned MTuserW = 2;
	localparam int unsigned CfgIdxW = 1;
	localparam int unsigned CfgDataW = 16;

	// operation codes on s_tuser
	localparam logic [OpW-1:0] OP_DATA        = 3'd0;
	localparam logic [OpW-1:0] OP_CONNECT     = 3'd1;
	localparam logic [OpW-1:0] OP_SUBSCRIBE   = 3'd2;
	localparam logic [OpW-1:0] OP_UNSUBSCRIBE = 3'd3;
	localparam logic [OpW-1:0] OP_PUBLISH     = 3'd4;
	localparam logic [OpW-1:0] OP_PING        = 3'd5;
	localparam logic [OpW-1:0] OP_DISCONNECT  = 3'd6;
	localparam logic [OpW-1:0] OP_RESERVED    = 3'd7;

	// m_tuser bit positions
	localparam int unsigned USER_RUN_LAST = 0;
	localparam int unsigned USER_ERROR    = 1;

	// configuration register indexes
	localparam logic [CfgIdxW-1:0] CFG_KEEP_ALIVE    = 1'b0;
	localparam logic [CfgIdxW-1:0] CFG_CONNECT_FLAGS = 1'b1;

	localparam logic [LenW-1:0]  KEEP_ALIVE_RST    = 16'd50;
	localparam logic [ByteW-1:0] CONNECT_FLAGS_RST = 8'hC2;

	// fixed header first bytes
	localparam logic [ByteW-1:0] HDR_CONNECT = 8'h10;
	localparam logic [ByteW-1:0] HDR_SUB     = 8'h82;
	localparam logic [ByteW-1:0] HDR_UNSUB   = 8'hA2;
	localparam logic [ByteW-1:0] HDR_PUB     = 8'h30;
	localparam logic [ByteW-1:0] HDR_PING    = 8'hC0;
	localparam logic [ByteW-1:0] HDR_DISC    = 8'hE0;
	localparam logic [ByteW-1:0] PROTO_LEVEL = 8'h04;
	localparam logic [ByteW-1:0] SUB_PID_LSB = 8'h01;

	typedef enum logic [2:0] {
		RUN_ERR,
		RUN_DATA,
		RUN_CTRL,
		RUN_CONNECT,
		RUN_SUB,
		RUN_UNSUB,
		RUN_PUB
	} run_t;

	// bytes appended after a string segment completes
	typedef struct packed {
		logic [1:0]       len;
		logic [ByteW-1:0] b0;
		logic [ByteW-1:0] b1;
		logic             close;
	} tail_t;

endpackage

// ===== rtl/mqtt_control_packet_framer.sv =====
// MQTT 3.1.1 control packet framer. Each input beat on s_* (s_tuser is the
// operation) either opens a packet (CONNECT, SUBSCRIBE, UNSUBSCRIBE, PUBLISH),
// sends a complete PINGREQ or DISCONNECT, or carries one string byte of the
// open packet. The block answers with a run of output bytes on m_*: the fixed
// header with its remaining-length field, the variable header and length
// prefixes, then the string bytes as they arrive, with the next length prefix,
// the SUBSCRIBE QoS byte or the PUBLISH packet id inserted where a string ends.
// m_tlast marks the final byte of a packet, m_tuser[0] the last byte of the
// run caused by one input beat, m_tuser[1] an out-of-sequence beat (one zero
// byte, state untouched). An input beat yields 1 to 18 output bytes, one per
// cycle barring stalls; the byte sequencer holds a beat until its last byte
// goes to the output register, so a string byte that ends no segment passes at
// one beat per cycle barring stalls, and a header beat occupies the sequencer
// for its run length. The output register lets the next beat enter while the
// last byte still waits on m_tready. Configuration (keep-alive, connect flags)
// may be written only while the block is idle; cfg_ready is always 1.
module mqtt_control_packet_framer
	import mcpf_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	// s_tdata, from bit 0: data_byte[7:0], first_length[15:0],
	// second_length[15:0], third_length[15:0], qos_level[1:0], zero pad
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [STdataW-1:0]  s_tdata,
	input  logic [OpW-1:0]      s_tuser,	// operation
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [ByteW-1:0]    m_tdata,	// out_byte
	output logic                m_tlast,	// packet_end
	output logic [MTuserW-1:0]  m_tuser,	// from bit 0: run_last, error_flag
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_data
);

	// input fields
	logic [ByteW-1:0] in_data;
	logic [LenW-1:0]  in_l1, in_l2, in_l3;
	logic [QosW-1:0]  in_qos;
	assign in_data = s_tdata[7:0];
	assign in_l1   = s_tdata[23:8];
	assign in_l2   = s_tdata[39:24];
	assign in_l3   = s_tdata[55:40];
	assign in_qos  = s_tdata[57:56];

	// configuration
	logic [LenW-1:0]  keep_alive_q;
	logic [ByteW-1:0] flags_q;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keep_alive_q <= KEEP_ALIVE_RST;
			flags_q      <= CONNECT_FLAGS_RST;
		end else if (cfg_valid) begin
			if (cfg_index == CFG_KEEP_ALIVE)
				keep_alive_q <= cfg_data;
			else
				flags_q <= cfg_data[ByteW-1:0];
		end
	end

	// packet state, updated when a beat is accepted
	logic            open_q, open_d;
	logic [OpW-1:0]  kind_q, kind_d;
	logic [1:0]      seg_q, seg_d;
	logic [LenW-1:0] left_q, left_d;
	logic [LenW-1:0] p0_q, p0_d, p1_q, p1_d;
	logic [QosW-1:0] qos_q, qos_d;
	logic [LenW-1:0] pid_q, pid_d;

	logic  in_acc, is_hdr, is_ctrl, bad, seg_run;
	tail_t tail;

	assign in_acc  = s_tvalid && s_tready;
	assign is_hdr  = (s_tuser == OP_CONNECT) || (s_tuser == OP_SUBSCRIBE) ||
	                 (s_tuser == OP_UNSUBSCRIBE) || (s_tuser == OP_PUBLISH);
	assign is_ctrl = (s_tuser == OP_PING) || (s_tuser == OP_DISCONNECT);
	assign bad     = (s_tuser == OP_DATA) ? !open_q
	                                      : (open_q || s_tuser == OP_RESERVED);

	// Next state plus the bytes appended when a string segment ends. A header
	// whose first string is empty runs the end-of-segment step on the state
	// it just set up.
	always_comb begin
		open_d  = open_q;
		kind_d  = kind_q;
		seg_d   = seg_q;
		left_d  = left_q;
		p0_d    = p0_q;
		p1_d    = p1_q;
		qos_d   = qos_q;
		pid_d   = pid_q;
		tail    = '0;
		seg_run = 1'b0;
		if (!bad && s_tuser == OP_DATA) begin
			left_d  = (left_q != '0) ? left_q - 1'b1 : left_q;
			seg_run = (left_d == '0);
		end else if (!bad && is_hdr) begin
			kind_d  = s_tuser;
			qos_d   = in_qos;
			seg_d   = '0;
			p0_d    = (s_tuser == OP_CONNECT || s_tuser == OP_PUBLISH) ? in_l2 : '0;
			p1_d    = (s_tuser == OP_CONNECT) ? in_l3 : '0;
			open_d  = 1'b1;
			left_d  = in_l1;
			seg_run = (in_l1 == '0);
		end
		if (seg_run) begin
			tail.close = 1'b1;
			case (kind_d)
				OP_CONNECT: begin
					if (seg_d == 2'd0 && p0_d != '0) begin
						seg_d      = 2'd1;
						left_d     = p0_d;
						tail.len   = 2'd2;
						tail.b0    = p0_d[15:8];
						tail.b1    = p0_d[7:0];
						tail.close = 1'b0;
					end else if (seg_d <= 2'd1 && p1_d != '0) begin
						seg_d      = 2'd2;
						left_d     = p1_d;
						tail.len   = 2'd2;
						tail.b0    = p1_d[15:8];
						tail.b1    = p1_d[7:0];
						tail.close = 1'b0;
					end
				end
				OP_SUBSCRIBE: begin
					tail.len = 2'd1;
					tail.b0  = {{(ByteW-QosW){1'b0}}, qos_d};
				end
				OP_PUBLISH: begin
					if (seg_d == 2'd0) begin
						if (qos_d != '0) begin
							tail.len = 2'd2;
							tail.b0  = pid_q[15:8];
							tail.b1  = pid_q[7:0];
							pid_d    = pid_q + 1'b1;
						end
						if (p0_d != '0) begin
							seg_d      = 2'd1;
							left_d     = p0_d;
							tail.close = 1'b0;
						end
					end
				end
				default: ;
			endcase
			if (tail.close) begin
				open_d = 1'b0;
				left_d = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= 1'b0;
			kind_q <= '0;
			seg_q  <= '0;
			left_q <= '0;
			p0_q   <= '0;
			p1_q   <= '0;
			qos_q  <= '0;
			pid_q  <= '0;
		end else if (in_acc) begin
			open_q <= open_d;
			kind_q <= kind_d;
			seg_q  <= seg_d;
			left_q <= left_d;
			p0_q   <= p0_d;
			p1_q   <= p1_d;
			qos_q  <= qos_d;
			pid_q  <= pid_d;
		end
	end

	// run description for the byte sequencer
	run_t             run_in;
	logic [RemW-1:0]  rem_in;
	logic [RlW-1:0]   rl_n_in;
	logic [IdxW-1:0]  body_len_in;
	logic [ByteW-1:0] byte_in;

	always_comb begin
		run_in  = RUN_ERR;
		byte_in = in_data;
		rem_in  = '0;
		if (bad) begin
			run_in = RUN_ERR;
		end else begin
			case (s_tuser)
				OP_DATA:        run_in = RUN_DATA;
				OP_CONNECT:     run_in = RUN_CONNECT;
				OP_SUBSCRIBE:   run_in = RUN_SUB;
				OP_UNSUBSCRIBE: run_in = RUN_UNSUB;
				OP_PUBLISH:     run_in = RUN_PUB;
				default:        run_in = RUN_CTRL;
			endcase
		end
		if (s_tuser == OP_PING)
			byte_in = HDR_PING;
		else if (s_tuser == OP_DISCONNECT)
			byte_in = HDR_DISC;
		case (s_tuser)
			OP_CONNECT:
				rem_in = RemW'(12) + {2'b0, in_l1}
				       + ((in_l2 != '0) ? {2'b0, in_l2} + RemW'(2) : '0)
				       + ((in_l3 != '0) ? {2'b0, in_l3} + RemW'(2) : '0);
			OP_SUBSCRIBE:   rem_in = RemW'(5) + {2'b0, in_l1};
			OP_UNSUBSCRIBE: rem_in = RemW'(4) + {2'b0, in_l1};
			OP_PUBLISH:
				rem_in = RemW'(2) + {2'b0, in_l1} + {2'b0, in_l2}
				       + ((in_qos != '0) ? RemW'(2) : '0);
			default: rem_in = '0;
		endcase
		if (rem_in < RemW'(128))
			rl_n_in = 2'd1;
		else if (rem_in < RemW'(16384))
			rl_n_in = 2'd2;
		else
			rl_n_in = 2'd3;
		// bytes before the tail: header byte, remaining length, fixed part
		case (run_in)
			RUN_CTRL:    body_len_in = IdxW'(2);
			RUN_CONNECT: body_len_in = IdxW'(13) + {3'b0, rl_n_in};
			RUN_SUB,
			RUN_UNSUB:   body_len_in = IdxW'(5) + {3'b0, rl_n_in};
			RUN_PUB:     body_len_in = IdxW'(3) + {3'b0, rl_n_in};
			default:     body_len_in = IdxW'(1);
		endcase
	end

	// sequencer stage: holds one beat, emits one byte per cycle while the output register can take it
	logic             valid_s1;
	logic [IdxW-1:0]  idx_s1;
	run_t             run_s1;
	logic [ByteW-1:0] byte_s1;
	logic [LenW-1:0]  l1_s1;
	logic [QosW-1:0]  qos_s1;
	logic [RemW-1:0]  rem_s1;
	logic [RlW-1:0]   rl_n_s1;
	logic [IdxW-1:0]  body_len_s1;
	logic [IdxW-1:0]  last_idx_s1;
	tail_t            tail_s1;

	logic emit, last_emit, at_last;

	// output register
	logic             valid_s2;
	logic [ByteW-1:0] byte_s2;
	logic             end_s2, last_s2, err_s2;

	assign at_last   = (idx_s1 == last_idx_s1);
	assign emit      = valid_s1 && (!valid_s2 || m_tready);
	assign last_emit = emit && at_last;
	assign s_tready  = !valid_s1 || last_emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			idx_s1   <= '0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
			idx_s1   <= '0;
		end else if (emit) begin
			valid_s1 <= !at_last;
			idx_s1   <= idx_s1 + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			run_s1      <= run_in;
			byte_s1     <= byte_in;
			l1_s1       <= in_l1;
			qos_s1      <= in_qos;
			rem_s1      <= rem_in;
			rl_n_s1     <= rl_n_in;
			body_len_s1 <= body_len_in;
			last_idx_s1 <= body_len_in + {3'b0, tail.len} - 1'b1;
			// PINGREQ and DISCONNECT end their packet on their own
			tail_s1     <= '{len: tail.len, b0: tail.b0, b1: tail.b1,
			                 close: is_ctrl ? !bad : tail.close};
		end
	end

	// byte at the current index
	logic [ByteW-1:0] cur_byte;
	logic [IdxW-1:0]  fix_j;
	logic [ByteW-1:0] hdr_byte, rl_byte;

	assign fix_j = idx_s1 - 1'b1 - {3'b0, rl_n_s1};

	always_comb begin
		case (run_s1)
			RUN_CONNECT: hdr_byte = HDR_CONNECT;
			RUN_SUB:     hdr_byte = HDR_SUB;
			RUN_UNSUB:   hdr_byte = HDR_UNSUB;
			default:     hdr_byte = HDR_PUB | {5'b0, qos_s1, 1'b0};
		endcase
		case (idx_s1)
			IdxW'(1): rl_byte = {(rl_n_s1 > 2'd1), rem_s1[6:0]};
			IdxW'(2): rl_byte = {(rl_n_s1 > 2'd2), rem_s1[13:7]};
			default:  rl_byte = {4'b0, rem_s1[17:14]};
		endcase
		cur_byte = '0;
		if (idx_s1 >= body_len_s1) begin
			cur_byte = (idx_s1 == body_len_s1) ? tail_s1.b0 : tail_s1.b1;
		end else begin
			case (run_s1)
				RUN_ERR:  cur_byte = '0;
				RUN_DATA: cur_byte = byte_s1;
				RUN_CTRL: cur_byte = (idx_s1 == '0) ? byte_s1 : '0;
				default: begin
					if (idx_s1 == '0) begin
						cur_byte = hdr_byte;
					end else if (idx_s1 <= {3'b0, rl_n_s1}) begin
						cur_byte = rl_byte;
					end else if (run_s1 == RUN_CONNECT) begin
						case (fix_j)
							IdxW'(0):  cur_byte = 8'h00;
							IdxW'(1):  cur_byte = PROTO_LEVEL;
							IdxW'(2):  cur_byte = "M";
							IdxW'(3):  cur_byte = "Q";
							IdxW'(4):  cur_byte = "T";
							IdxW'(5):  cur_byte = "T";
							IdxW'(6):  cur_byte = PROTO_LEVEL;
							IdxW'(7):  cur_byte = flags_q;
							IdxW'(8):  cur_byte = keep_alive_q[15:8];
							IdxW'(9):  cur_byte = keep_alive_q[7:0];
							IdxW'(10): cur_byte = l1_s1[15:8];
							default:   cur_byte = l1_s1[7:0];
						endcase
					end else if (run_s1 == RUN_PUB) begin
						cur_byte = (fix_j == '0) ? l1_s1[15:8] : l1_s1[7:0];
					end else begin
						// SUBSCRIBE / UNSUBSCRIBE: packet id 1, topic prefix
						case (fix_j)
							IdxW'(0): cur_byte = 8'h00;
							IdxW'(1): cur_byte = SUB_PID_LSB;
							IdxW'(2): cur_byte = l1_s1[15:8];
							default:  cur_byte = l1_s1[7:0];
						endcase
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2 <= 1'b0;
		else if (emit)
			valid_s2 <= 1'b1;
		else if (m_tready)
			valid_s2 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			byte_s2 <= cur_byte;
			end_s2  <= tail_s1.close && at_last;
			last_s2 <= at_last;
			err_s2  <= (run_s1 == RUN_ERR);
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = byte_s2;
	assign m_tlast  = end_s2;
	assign m_tuser  = {err_s2, last_s2};

endmodule

// ===== rtl/mcpf_checker.sv =====
module mcpf_checker
	import mcpf_pkg::*;
(
	input logic                clk,
	input logic                arst_n,
	input logic                m_tvalid,
	input logic                m_tready,
	input logic [ByteW-1:0]    m_tdata,
	input logic                m_tlast,
	input logic [MTuserW-1:0]  m_tuser
);

	// an error beat is a lone zero byte that ends its run and no packet
	a_err_beat: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[USER_ERROR] |->
			m_tdata == '0 && !m_tlast && m_tuser[USER_RUN_LAST])
		else $error("error beat malformed");

	// a packet only closes on the last byte of a run
	a_end_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tuser[USER_RUN_LAST])
		else $error("packet end inside a run");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=>
			m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser))
		else $error("stalled output beat changed");

endmodule

bind mqtt_control_packet_framer mcpf_checker u_mcpf_checker (.*);

// ===== sim/mqtt_control_packet_framer_test.sv =====
`timescale 1ns / 100ps

// Testbench for the MQTT control packet framer.
// Input beats (headers and string bytes) go in on s_*, and the framed byte
// stream comes back on m_*. Every accepted input beat is run through a local
// packet model at the moment of acceptance. The model queues the bytes that
// the beat should produce. A checker pops one expected byte per output beat
// and compares data, packet end, run end and error flag.
module mqtt_control_packet_framer_test;
	import mcpf_pkg::*;

	localparam int unsigned WATCHDOG_LIMIT = 5000;	// cycles with no beat at all
	localparam int unsigned RANDOM_ITEMS   = 70;
	localparam int unsigned MAX_REPORTS    = 10;
	localparam logic [LenW-1:0] PROTO_NAME_LEN = 16'd4;	// "MQTT"

	// one expected output beat
	typedef struct {
		logic [ByteW-1:0] octet;
		logic             pkt_end;
		logic             run_end;
		logic             err;
	} framed_beat_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic               s_tvalid = 1'b0;
	logic               s_tready;
	logic [STdataW-1:0] s_tdata = '0;
	logic [OpW-1:0]     s_tuser = OP_DATA;
	logic               m_tvalid;
	logic               m_tready = 1'b0;
	logic [ByteW-1:0]   m_tdata;
	logic               m_tlast;
	logic [MTuserW-1:0] m_tuser;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [CfgIdxW-1:0] cfg_index = CFG_KEEP_ALIVE;
	logic [CfgDataW-1:0] cfg_data = '0;

	mqtt_control_packet_framer DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	// ---------------------------------------------------------------
	// Packet model: its own copy of the framer state and registers.
	// ---------------------------------------------------------------
	logic [LenW-1:0]  keep_alive;
	logic [ByteW-1:0] conn_flags;
	logic             pkt_open;
	logic [OpW-1:0]   pkt_kind;
	logic [1:0]       seg_idx;
	logic [LenW-1:0]  seg_left;
	logic [LenW-1:0]  pend_len [2];
	logic [QosW-1:0]  held_qos;
	logic [LenW-1:0]  pub_id;

	framed_beat_t run_q[$];           // bytes of the beat being modeled
	framed_beat_t frame_expect_q[$];  // bytes still owed by the block

	// test bookkeeping
	logic        stall_en = 1'b1;     // random idling on both sides
	int unsigned mismatch_cnt = 0;
	int unsigned stray_cnt = 0;
	int unsigned items_sent = 0;
	int unsigned items_ok = 0;
	int unsigned beats_checked = 0;
	int unsigned packets_seen = 0;
	int unsigned cfg_writes = 0;
	int unsigned quiet_cycles = 0;

	function automatic void emit(input logic [ByteW-1:0] b);
		framed_beat_t beat;
		beat.octet = b;
		beat.pkt_end = 1'b0;
		beat.run_end = 1'b0;
		beat.err = 1'b0;
		run_q.push_back(beat);
	endfunction

	function automatic void emit16(input logic [LenW-1:0] v);
		emit(v[15:8]);
		emit(v[7:0]);
	endfunction

	// variable-length remaining-length field, 7 bits per byte, LSB group first
	function automatic void emit_remlen(input int unsigned len);
		int unsigned v;
		logic [ByteW-1:0] b;
		v = len;
		do begin
			b = 8'(v % 128);
			v = v / 128;
			if (v > 0)
				b[7] = 1'b1;
			emit(b);
		end while (v > 0);
	endfunction

	function automatic void close_pkt();
		pkt_open = 1'b0;
		seg_left = '0;
		if (run_q.size() > 0)
			run_q[run_q.size()-1].pkt_end = 1'b1;
	endfunction

	// current string fully passed: insert what follows it, or close
	function automatic void string_done();
		case (pkt_kind)
			OP_CONNECT: begin
				if (seg_idx == 2'd0 && pend_len[0] != 0) begin
					seg_idx = 2'd1;
					emit16(pend_len[0]);
					seg_left = pend_len[0];
					return;
				end
				if (seg_idx <= 2'd1 && pend_len[1] != 0) begin
					seg_idx = 2'd2;
					emit16(pend_len[1]);
					seg_left = pend_len[1];
					return;
				end
			end
			OP_SUBSCRIBE: emit({6'd0, held_qos});
			OP_PUBLISH: begin
				if (seg_idx == 2'd0) begin
					if (held_qos != 0) begin
						emit16(pub_id);
						pub_id = pub_id + 16'd1;
					end
					if (pend_len[0] != 0) begin
						seg_idx = 2'd1;
						seg_left = pend_len[0];
						return;
					end
				end
			end
			default: ;
		endcase
		close_pkt();
	endfunction

	// expected output bytes for one accepted input beat
	function automatic void frame_model_step(input logic [OpW-1:0] op,
			input logic [ByteW-1:0] dbyte, input logic [LenW-1:0] l1,
			input logic [LenW-1:0] l2, input logic [LenW-1:0] l3,
			input logic [QosW-1:0] qos);
		logic bad;
		int unsigned rem;
		run_q.delete();
		bad = (op == OP_DATA) ? !pkt_open : (pkt_open || op == OP_RESERVED);
		if (bad) begin
			emit(8'h00);
			run_q[0].err = 1'b1;
		end else if (op == OP_DATA) begin
			emit(dbyte);
			if (seg_left != 0)
				seg_left = seg_left - 16'd1;
			if (seg_left == 0)
				string_done();
		end else if (op == OP_PING || op == OP_DISCONNECT) begin
			emit(op == OP_PING ? HDR_PING : HDR_DISC);
			emit(8'h00);
			run_q[1].pkt_end = 1'b1;
		end else begin
			pkt_kind = op;
			held_qos = qos;
			seg_idx = 2'd0;
			pend_len[0] = '0;
			pend_len[1] = '0;
			if (op == OP_CONNECT) begin
				pend_len[0] = l2;
				pend_len[1] = l3;
				rem = 10 + l1 + 2;
				if (l2 != 0)
					rem += l2 + 2;
				if (l3 != 0)
					rem += l3 + 2;
				emit(HDR_CONNECT);
				emit_remlen(rem);
				emit16(PROTO_NAME_LEN);
				emit(8'h4D);	// M
				emit(8'h51);	// Q
				emit(8'h54);	// T
				emit(8'h54);	// T
				emit(PROTO_LEVEL);
				emit(conn_flags);
				emit16(keep_alive);
			end else if (op == OP_SUBSCRIBE || op == OP_UNSUBSCRIBE) begin
				rem = 2 + l1 + 2 + (op == OP_SUBSCRIBE ? 1 : 0);
				emit(op == OP_SUBSCRIBE ? HDR_SUB : HDR_UNSUB);
				emit_remlen(rem);
				emit16({8'h00, SUB_PID_LSB});
			end else begin
				pend_len[0] = l2;
				rem = 2 + l1 + (qos != 0 ? 2 : 0) + l2;
				emit(HDR_PUB | {5'd0, qos, 1'b0});
				emit_remlen(rem);
			end
			emit16(l1);
			pkt_open = 1'b1;
			seg_left = l1;
			if (l1 == 0)
				string_done();
		end
		run_q[run_q.size()-1].run_end = 1'b1;
		foreach (run_q[i])
			frame_expect_q.push_back(run_q[i]);
	endfunction

	// ---------------------------------------------------------------
	// Output side: random back-pressure and the byte checker.
	// ---------------------------------------------------------------
	always @(posedge clk)
		m_tready <= !stall_en || ($urandom_range(0, 99) >= 25);

	always @(posedge clk) begin : check_out
		framed_beat_t want;
		if (arst_n && m_tvalid && m_tready) begin
			beats_checked++;
			if (m_tlast === 1'b1)
				packets_seen++;
			if (frame_expect_q.size() == 0) begin
				stray_cnt++;
				if (mismatch_cnt + stray_cnt <= MAX_REPORTS)
					$display("%0t: unexpected beat: data %02h last %b user %b",
						$realtime, m_tdata, m_tlast, m_tuser);
			end else begin
				want = frame_expect_q.pop_front();
				if (m_tdata !== want.octet || m_tlast !== want.pkt_end ||
						m_tuser[USER_RUN_LAST] !== want.run_end ||
						m_tuser[USER_ERROR] !== want.err) begin
					mismatch_cnt++;
					if (mismatch_cnt + stray_cnt <= MAX_REPORTS) begin
						$display("%0t: beat %0d mismatch: exp data %02h last %b run %b err %b",
							$realtime, beats_checked, want.octet, want.pkt_end,
							want.run_end, want.err);
						$display("    got data %02h last %b run %b err %b",
							m_tdata, m_tlast, m_tuser[USER_RUN_LAST],
							m_tuser[USER_ERROR]);
					end
				end
			end
		end
	end

	// watchdog: any accepted beat on any channel restarts the count
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: watchdog expired, %0d bytes still expected",
				$realtime, frame_expect_q.size());
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// Stimulus helpers
	// ---------------------------------------------------------------
	// Sends one input beat; tvalid stays high on return so back-to-back
	// beats need no drop. A random idle gap lowers it first.
	task automatic send_item(input logic [OpW-1:0] op, input logic [ByteW-1:0] dbyte,
			input logic [LenW-1:0] l1, input logic [LenW-1:0] l2,
			input logic [LenW-1:0] l3, input logic [QosW-1:0] qos);
		while (stall_en && $urandom_range(0, 99) < 25) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {6'd0, qos, l3, l2, l1, dbyte};
		do
			@(posedge clk);
		while (!s_tready);
		frame_model_step(op, dbyte, l1, l2, l3, qos);
		items_sent++;
		if (!run_q[0].err)
			items_ok++;
	endtask

	task automatic send_header(input logic [OpW-1:0] op, input logic [LenW-1:0] l1,
			input logic [LenW-1:0] l2, input logic [LenW-1:0] l3,
			input logic [QosW-1:0] qos);
		send_item(op, 8'($urandom), l1, l2, l3, qos);
	endtask

	task automatic send_data(input logic [ByteW-1:0] dbyte);
		// length fields carry junk; the block must ignore them on data beats
		send_item(OP_DATA, dbyte, 16'($urandom), 16'($urandom), 16'($urandom),
			2'($urandom));
	endtask

	// feed random string bytes until the open packet closes
	task automatic finish_packet();
		while (pkt_open)
			send_data(8'($urandom));
	endtask

	// sender holds off until every owed byte is out and the block is quiet
	task automatic wait_frames_done();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (frame_expect_q.size() != 0)
			@(posedge clk);
		repeat (25) @(posedge clk);
	endtask

	task automatic write_cfg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		if (idx == CFG_KEEP_ALIVE)
			keep_alive = val;
		else
			conn_flags = val[ByteW-1:0];
		cfg_writes++;
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// ---------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------
	// reset register values in CONNECT, plus PINGREQ and DISCONNECT
	task automatic test_reset_values();
		send_header(OP_CONNECT, 16'd3, 16'd0, 16'd0, 2'd0);
		send_data(8'h00);
		send_data(8'hFF);
		send_data(8'h5A);
		send_header(OP_PING, 16'hFFFF, 16'hFFFF, 16'hFFFF, 2'd3);
		send_header(OP_DISCONNECT, 16'd0, 16'd0, 16'd0, 2'd0);
		wait_frames_done();
	endtask

	// headers inside a packet, data outside one, reserved opcode
	task automatic test_out_of_sequence();
		send_data(8'hFF);
		send_header(OP_RESERVED, 16'd1, 16'd1, 16'd1, 2'd1);
		send_header(OP_SUBSCRIBE, 16'd2, 16'd0, 16'd0, 2'd1);
		send_data(8'h41);
		send_header(OP_CONNECT, 16'd1, 16'd1, 16'd1, 2'd0);
		send_header(OP_RESERVED, 16'd0, 16'd0, 16'd0, 2'd0);
		send_header(OP_PING, 16'd0, 16'd0, 16'd0, 2'd0);
		send_data(8'h42);
		send_data(8'h00);
		wait_frames_done();
	endtask

	// zero-length strings, including packets that close in their header run
	task automatic test_empty_strings();
		send_header(OP_CONNECT, 16'd0, 16'd0, 16'd0, 2'd0);
		send_header(OP_SUBSCRIBE, 16'd0, 16'd0, 16'd0, 2'd2);
		send_header(OP_UNSUBSCRIBE, 16'd0, 16'd0, 16'd0, 2'd0);
		send_header(OP_PUBLISH, 16'd0, 16'd0, 16'd0, 2'd0);
		send_header(OP_PUBLISH, 16'd0, 16'd0, 16'd0, 2'd1);
		send_header(OP_PUBLISH, 16'd0, 16'd3, 16'd0, 2'd2);
		finish_packet();
		send_header(OP_CONNECT, 16'd0, 16'd2, 16'd0, 2'd0);
		finish_packet();
		send_header(OP_CONNECT, 16'd0, 16'd0, 16'd2, 2'd0);
		finish_packet();
		wait_frames_done();
	endtask

	// every QoS value, three included, on PUBLISH; QoS three on SUBSCRIBE and UNSUBSCRIBE
	task automatic test_qos_levels();
		for (int q = 0; q < 4; q++) begin
			send_header(OP_PUBLISH, 16'd1, 16'd2, 16'd0, 2'(q));
			finish_packet();
		end
		send_header(OP_SUBSCRIBE, 16'd1, 16'd0, 16'd0, 2'd3);
		finish_packet();
		send_header(OP_UNSUBSCRIBE, 16'd2, 16'd0, 16'd0, 2'd3);
		finish_packet();
		wait_frames_done();
	endtask

	// register extremes; upper bits of the flags write must be dropped
	task automatic test_config_extremes();
		write_cfg(CFG_KEEP_ALIVE, 16'hFFFF);
		write_cfg(CFG_CONNECT_FLAGS, 16'h0000);
		send_header(OP_CONNECT, 16'd1, 16'd1, 16'd1, 2'd0);
		finish_packet();
		wait_frames_done();
		write_cfg(CFG_KEEP_ALIVE, 16'h0000);
		write_cfg(CFG_CONNECT_FLAGS, 16'hA5FF);
		send_header(OP_CONNECT, 16'd2, 16'd0, 16'd1, 2'd0);
		finish_packet();
		wait_frames_done();
	endtask

	// largest CONNECT header: three full-length strings, 3-byte remaining
	// length; only a few string bytes follow and the packet stays open
	task automatic test_max_lengths();
		stall_en = 1'b0;
		send_header(OP_CONNECT, 16'hFFFF, 16'hFFFF, 16'hFFFF, 2'd0);
		repeat (4)
			send_data(8'($urandom));
		wait_frames_done();
		stall_en = 1'b1;
	endtask

	function automatic logic [LenW-1:0] pick_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 75)
			return 16'($urandom_range(0, 4));
		return 16'($urandom_range(5, 24));
	endfunction

	// one well-formed packet with random content, sometimes with noise
	task automatic random_packet();
		int unsigned r;
		logic [OpW-1:0] op;
		r = $urandom_range(0, 99);
		if (r < 25)
			op = OP_CONNECT;
		else if (r < 45)
			op = OP_SUBSCRIBE;
		else if (r < 60)
			op = OP_UNSUBSCRIBE;
		else if (r < 90)
			op = OP_PUBLISH;
		else if (r < 95)
			op = OP_PING;
		else
			op = OP_DISCONNECT;
		send_header(op, pick_len(), pick_len(), pick_len(), 2'($urandom));
		while (pkt_open) begin
			if ($urandom_range(0, 14) == 0)
				send_header(3'($urandom_range(1, 7)), pick_len(), pick_len(),
					pick_len(), 2'($urandom));
			send_data(8'($urandom));
		end
		if ($urandom_range(0, 5) == 0)
			send_data(8'($urandom));
		if ($urandom_range(0, 9) == 0)
			send_header(OP_RESERVED, pick_len(), pick_len(), pick_len(), 2'($urandom));
	endtask

	task automatic test_random_traffic();
		int unsigned start_sent;
		bit cfg_changed;
		start_sent = items_sent;
		cfg_changed = 0;
		while (items_sent - start_sent < RANDOM_ITEMS) begin
			// middle stretch runs with no idling on either side
			stall_en = !((items_sent - start_sent) >= RANDOM_ITEMS / 3 &&
				(items_sent - start_sent) < 2 * RANDOM_ITEMS / 3);
			if (!cfg_changed && (items_sent - start_sent) >= RANDOM_ITEMS / 2) begin
				wait_frames_done();
				write_cfg(CFG_KEEP_ALIVE, 16'($urandom));
				write_cfg(CFG_CONNECT_FLAGS, 16'($urandom));
				cfg_changed = 1;
			end
			random_packet();
		end
		stall_en = 1'b1;
		wait_frames_done();
	endtask

	// ---------------------------------------------------------------
	// Sequence
	// ---------------------------------------------------------------
	initial begin
		keep_alive = KEEP_ALIVE_RST;
		conn_flags = CONNECT_FLAGS_RST;
		pkt_open = 1'b0;
		pkt_kind = OP_DATA;
		seg_idx = 2'd0;
		seg_left = '0;
		pend_len[0] = '0;
		pend_len[1] = '0;
		held_qos = '0;
		pub_id = '0;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		test_reset_values();
		test_out_of_sequence();
		test_empty_strings();
		test_qos_levels();
		test_config_extremes();
		test_random_traffic();
		test_max_lengths();

		$display("Covered %0d input beats (%0d in sequence), %0d output bytes in %0d packets,",
			items_sent, items_ok, beats_checked, packets_seen);
		$display("%0d register writes, all error cases, empty strings, largest header.",
			cfg_writes);
		if (mismatch_cnt == 0 && stray_cnt == 0 && frame_expect_q.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("%0d mismatches, %0d unexpected beats, %0d bytes never seen",
				mismatch_cnt, stray_cnt, frame_expect_q.size());
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/mcpf_pkg.sv
rtl/mqtt_control_packet_framer.sv
rtl/mcpf_checker.sv
sim/mqtt_control_packet_framer_test.sv
